@@ sv/mcmp_pkg.sv @@
package mcmp_pkg;

  // System bytes of interest
  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;

  // Status nibble values
  localparam logic [3:0] TYPE_NOTE_OFF     = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON      = 4'h9;
  localparam logic [3:0] TYPE_POLY_PRESS   = 4'hA;
  localparam logic [3:0] TYPE_PROG_CHANGE  = 4'hC;
  localparam logic [3:0] TYPE_CHAN_PRESS   = 4'hD;
  localparam logic [3:0] TYPE_PITCH_BEND   = 4'hE;
  localparam logic [3:0] TYPE_SYSTEM       = 4'hF;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DATA_W = 7;
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned OUT_W  = 32;

  typedef struct packed {
    logic [DATA_W-1:0] note_number;
    logic [DATA_W-1:0] data_high;
    logic [DATA_W-1:0] data_low;
    logic [NIB_W-1:0]  channel;
    logic [NIB_W-1:0]  message_type;
  } msg_t;

endpackage

@@ sv/midi_channel_message_parser_top.sv @@
// MIDI channel message parser. One byte beat is taken per cycle on the in_
// channel; a beat is held in an input register and then parsed against the
// latched status into the result register, and a new byte can be taken every
// cycle while the out_ channel keeps up, even as the last byte is parsed. Channel
// status bytes 0x80..0xEF open a message; note off, note on, poly
// pressure, control change and pitch bend complete after two data bytes,
// program change and channel pressure after one (data_high then reads zero).
// A status byte arriving while data is awaited aborts the message and is
// dropped. 0xF0 when idle starts a SysEx skip that 0xF7 ends; other idle
// bytes are ignored. Running status is not supported. note_number carries the
// first data byte for note and poly pressure messages and is zero otherwise.
// Only completed messages produce an out_ beat.
module midi_channel_message_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] midi_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [3:0] message_type, [7:4] channel,
                                  // [14:8] data_low, [21:15] data_high,
                                  // [28:22] note_number, [31:29] zero
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_DATA1 = 2'd1,
    ST_DATA2 = 2'd2,
    ST_SKIP  = 2'd3
  } state_t;

  state_t                                 state_r, state_nxt;
  logic                                   byte_vld_r;
  logic [mcmp_pkg::BYTE_W-1:0]            byte_r;
  logic [mcmp_pkg::BYTE_W-1:0]            status_r, status_nxt;
  logic [mcmp_pkg::DATA_W-1:0]            first_r, first_nxt;
  logic                                   out_vld_r, out_vld_nxt;
  mcmp_pkg::msg_t                         msg_r, msg_nxt;

  logic                                   advance;
  logic                                   emit;
  logic                                   is_status;
  logic                                   is_chan_status;
  logic [mcmp_pkg::NIB_W-1:0]             cur_type;
  logic                                   one_data;
  logic [mcmp_pkg::DATA_W-1:0]            d1, d2;

  // Parse stage moves when a byte is held and the result slot is free or draining
  assign advance   = byte_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !byte_vld_r || advance;

  assign is_status      = byte_r[7];
  assign is_chan_status = byte_r[7] && (byte_r[7:4] != mcmp_pkg::TYPE_SYSTEM);
  assign cur_type       = status_r[7:4];
  assign one_data       = (cur_type == mcmp_pkg::TYPE_PROG_CHANGE) ||
                          (cur_type == mcmp_pkg::TYPE_CHAN_PRESS);

  // Parse one byte against the latched status
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    first_nxt  = first_r;
    emit       = 1'b0;
    d1         = byte_r[6:0];
    d2         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (byte_r == mcmp_pkg::SYSEX_START) begin
          state_nxt = ST_SKIP;
        end else if (is_chan_status) begin
          status_nxt = byte_r;
          state_nxt  = ST_DATA1;
        end
      end
      ST_DATA1: begin
        if (is_status) begin
          state_nxt = ST_IDLE;
        end else if (one_data) begin
          state_nxt = ST_IDLE;
          emit      = 1'b1;
        end else begin
          first_nxt = byte_r[6:0];
          state_nxt = ST_DATA2;
        end
      end
      ST_DATA2: begin
        state_nxt = ST_IDLE;
        emit      = !is_status;
        d1        = first_r;
        d2        = byte_r[6:0];
      end
      ST_SKIP: begin
        if (byte_r == mcmp_pkg::SYSEX_END) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Build the result beat
  always_comb begin
    msg_nxt              = msg_r;
    msg_nxt.message_type = cur_type;
    msg_nxt.channel      = status_r[3:0];
    msg_nxt.data_low     = d1;
    msg_nxt.data_high    = one_data ? '0 : d2;
    msg_nxt.note_number  = ((cur_type == mcmp_pkg::TYPE_NOTE_OFF) ||
                            (cur_type == mcmp_pkg::TYPE_NOTE_ON)  ||
                            (cur_type == mcmp_pkg::TYPE_POLY_PRESS)) ? d1 : '0;
    if (advance && emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // Hold state, input register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      byte_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (in_tready) begin
        byte_vld_r <= in_tvalid;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
    end
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
    end
    if (advance) begin
      status_r <= status_nxt;
      first_r  <= first_nxt;
    end
    if (advance && emit) begin
      msg_r <= msg_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(mcmp_pkg::OUT_W - $bits(mcmp_pkg::msg_t)){1'b0}}, msg_r};

  // Checks
  a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (msg_r.message_type >= mcmp_pkg::TYPE_NOTE_OFF) &&
                  (msg_r.message_type <= mcmp_pkg::TYPE_PITCH_BEND))
    else $error("result type outside channel message range");

  a_note_only_notes: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (msg_r.note_number != '0) |->
      (msg_r.message_type == mcmp_pkg::TYPE_NOTE_OFF) ||
      (msg_r.message_type == mcmp_pkg::TYPE_NOTE_ON) ||
      (msg_r.message_type == mcmp_pkg::TYPE_POLY_PRESS))
    else $error("note number set on non-note message");

  a_one_data_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && ((msg_r.message_type == mcmp_pkg::TYPE_PROG_CHANGE) ||
                  (msg_r.message_type == mcmp_pkg::TYPE_CHAN_PRESS)) |->
      (msg_r.data_high == '0))
    else $error("data_high set on one-data-byte message");

  a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && emit |=> (state_r == ST_IDLE) && out_vld_r)
    else $error("completed message did not return to idle");

  a_data2_two_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DATA2) |-> !one_data)
    else $error("one-data-byte message waiting for second byte");

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;

  localparam int unsigned CLK_HALF    = 4;
  localparam int unsigned SETTLE_CYC  = 8;
  localparam int unsigned DRAIN_LIMIT = 20000;

  // Parser states of the local model
  typedef enum logic [1:0] {
    PS_IDLE,
    PS_WAIT_D1,
    PS_WAIT_D2,
    PS_SYSEX_SKIP
  } parse_state_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] midi_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;  // [3:0] message_type, [7:4] channel, [14:8] data_low,
                           // [21:15] data_high, [28:22] note_number, [31:29] zero

  // Local copy of the parser state
  parse_state_t pstate;
  logic [7:0]   held_status;
  logic [6:0]   held_first;

  mcmp_pkg::msg_t pending_msgs[$];
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned mismatch_cnt = 0;
  int unsigned bytes_sent;
  int unsigned msgs_checked = 0;
  int unsigned drain_waits;
  bit          hard_fail;

  midi_channel_message_parser_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Run the parser model on one accepted byte; queue the message it completes
  task automatic parse_byte(input logic [7:0] b);
    mcmp_pkg::msg_t m;
    logic [3:0]     kind;
    kind = held_status[7:4];
    case (pstate)
      PS_IDLE: begin
        if (b == mcmp_pkg::SYSEX_START) begin
          pstate = PS_SYSEX_SKIP;
        end else if (b[7] && b[7:4] != mcmp_pkg::TYPE_SYSTEM) begin
          held_status = b;
          pstate      = PS_WAIT_D1;
        end
      end
      PS_WAIT_D1: begin
        if (b[7]) begin
          pstate = PS_IDLE;
        end else if (kind == mcmp_pkg::TYPE_PROG_CHANGE ||
                     kind == mcmp_pkg::TYPE_CHAN_PRESS) begin
          m.message_type = kind;
          m.channel      = held_status[3:0];
          m.data_low     = b[6:0];
          m.data_high    = '0;
          m.note_number  = '0;
          pending_msgs.push_back(m);
          pstate = PS_IDLE;
        end else begin
          held_first = b[6:0];
          pstate     = PS_WAIT_D2;
        end
      end
      PS_WAIT_D2: begin
        pstate = PS_IDLE;
        if (!b[7]) begin
          m.message_type = kind;
          m.channel      = held_status[3:0];
          m.data_low     = held_first;
          m.data_high    = b[6:0];
          m.note_number  = (kind == mcmp_pkg::TYPE_NOTE_OFF ||
                            kind == mcmp_pkg::TYPE_NOTE_ON ||
                            kind == mcmp_pkg::TYPE_POLY_PRESS) ? held_first : '0;
          pending_msgs.push_back(m);
        end
      end
      default: begin
        if (b == mcmp_pkg::SYSEX_END) pstate = PS_IDLE;
      end
    endcase
  endtask

  // Offer one byte beat, idling first at random; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    parse_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Hold the input quiet until every queued message has come out
  task automatic wait_drained();
    int unsigned n;
    in_tvalid <= 1'b0;
    n = 0;
    while (pending_msgs.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    if (pending_msgs.size() != 0) begin
      $display("drain timed out with %0d messages outstanding", pending_msgs.size());
      hard_fail = 1'b1;
    end
    repeat (SETTLE_CYC) @(negedge clk);
    drain_waits++;
  endtask

  function automatic logic [6:0] rand_data();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 7'h00;
    if (r == 1) return 7'h7F;
    return 7'($urandom_range(127));
  endfunction

  // Send one channel message; when cut short, a status byte aborts it
  task automatic send_message(input bit cut_short);
    logic [3:0]  kind;
    int unsigned n_data;
    int unsigned n_keep;
    kind   = 4'($urandom_range(mcmp_pkg::TYPE_NOTE_OFF, mcmp_pkg::TYPE_PITCH_BEND));
    n_data = (kind == mcmp_pkg::TYPE_PROG_CHANGE ||
              kind == mcmp_pkg::TYPE_CHAN_PRESS) ? 1 : 2;
    n_keep = cut_short ? $urandom_range(n_data - 1) : n_data;
    send_byte({kind, 4'($urandom_range(15))});
    repeat (n_keep) send_byte({1'b0, rand_data()});
    if (cut_short) send_byte(8'($urandom_range(8'h80, 8'hFF)));
  endtask

  // SysEx block with random content, stray status bytes other than its end among it
  task automatic send_sysex();
    logic [7:0] b;
    send_byte(mcmp_pkg::SYSEX_START);
    repeat ($urandom_range(6)) begin
      b = ($urandom_range(4) == 0) ? 8'($urandom_range(8'h80, 8'hFF))
                                   : {1'b0, rand_data()};
      if (b == mcmp_pkg::SYSEX_END) b = 8'hF8;
      send_byte(b);
    end
    send_byte(mcmp_pkg::SYSEX_END);
  endtask

  // Mostly well-formed messages, with aborted ones, SysEx blocks and loose bytes
  task automatic send_random_traffic(input int unsigned n_bytes);
    int unsigned start;
    int unsigned r;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      r = $urandom_range(99);
      if (r < 70)      send_message(1'b0);
      else if (r < 80) send_message(1'b1);
      else if (r < 90) send_sysex();
      else             send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic test_directed();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    // stray bytes while idle
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(mcmp_pkg::SYSEX_END);
    // one message of each type, field extremes
    send_byte(8'h80); send_byte(8'h00); send_byte(8'h7F);
    send_byte(8'h9F); send_byte(8'h7F); send_byte(8'h00);
    send_byte(8'hA5); send_byte(8'h12); send_byte(8'h34);
    send_byte(8'hB3); send_byte(8'h40); send_byte(8'h7F);
    send_byte(8'hC7); send_byte(8'h55);
    send_byte(8'hD0); send_byte(8'h7F);
    send_byte(8'hEF); send_byte(8'h00); send_byte(8'h7F);
    // abort while waiting for first data: SysEx start is dropped, not entered
    send_byte(8'h90); send_byte(mcmp_pkg::SYSEX_START); send_byte(8'h3C);
    // abort while waiting for second data
    send_byte(8'hB0); send_byte(8'h10); send_byte(8'hFE);
    // SysEx skip swallows a status byte and data until its end
    send_byte(mcmp_pkg::SYSEX_START); send_byte(8'h91); send_byte(8'h12);
    send_byte(mcmp_pkg::SYSEX_END);
    send_byte(8'hC1); send_byte(8'h00);
    wait_drained();
  endtask

  task automatic test_random_no_idle();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_random_traffic(300);
    wait_drained();
  endtask

  task automatic test_random_sender_idle();
    src_idle_pct   = 65;
    sink_stall_pct = 0;
    send_random_traffic(150);
    wait_drained();
    send_random_traffic(150);
    wait_drained();
  endtask

  task automatic test_random_receiver_stall();
    src_idle_pct   = 0;
    sink_stall_pct = 65;
    send_random_traffic(300);
    wait_drained();
  endtask

  task automatic test_random_both_idle();
    src_idle_pct   = 8;
    sink_stall_pct = 8;
    send_random_traffic(300);
    wait_drained();
  endtask

  // Receiver readiness, redrawn each cycle
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic flag_field(input string name, input int unsigned want, input int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
  endtask

  // Compare each result beat with the oldest queued message
  always @(posedge clk) begin : check_results
    mcmp_pkg::msg_t want;
    mcmp_pkg::msg_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = mcmp_pkg::msg_t'(out_tdata[28:0]);
      if (pending_msgs.size() == 0) begin
        flag_field("unexpected beat", 0, out_tdata);
      end else begin
        want = pending_msgs.pop_front();
        msgs_checked++;
        if (got.message_type != want.message_type)
          flag_field("message_type", want.message_type, got.message_type);
        if (got.channel != want.channel)
          flag_field("channel", want.channel, got.channel);
        if (got.data_low != want.data_low)
          flag_field("data_low", want.data_low, got.data_low);
        if (got.data_high != want.data_high)
          flag_field("data_high", want.data_high, got.data_high);
        if (got.note_number != want.note_number)
          flag_field("note_number", want.note_number, got.note_number);
        if (out_tdata[31:29] != 3'b000)
          flag_field("padding", 0, out_tdata[31:29]);
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = 8'h00;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    bytes_sent     = 0;
    drain_waits    = 0;
    hard_fail      = 1'b0;
    pstate         = PS_IDLE;
    held_status    = 8'h00;
    held_first     = 7'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();

    $display("covered: %0d bytes in, %0d channel messages compared", bytes_sent, msgs_checked);
    $display("all types, aborts, SysEx skips; %0d drain pauses under four idle mixes",
             drain_waits);
    if (mismatch_cnt == 0 && !hard_fail && pending_msgs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("status: fail");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #(2 * CLK_HALF * 400000);
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/mcmp_pkg.sv
sv/midi_channel_message_parser_top.sv
tb/sv/tb_top.sv
